// ===== design/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

  // s-box geometry
  localparam int SBOX_SIZE  = 256;
  localparam int SBOX_AW    = $clog2(SBOX_SIZE);

  // key storage geometry
  localparam int KEY_MAX    = 256;
  localparam int KEY_IDX_W  = $clog2(KEY_MAX);
  localparam int KEY_CNT_W  = $clog2(KEY_MAX + 1);

  typedef logic [7:0] byte_t;
  typedef logic [SBOX_AW-1:0] sbox_addr_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [KEY_CNT_W-1:0] key_cnt_t;

  // request codes
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

endpackage

`default_nettype wire

// ===== design/rc4_stream_cipher_unit.sv =====
// a data byte passes through KS_J, KS_WI, KS_WJ and KS_OUT; a new item is taken only
// once its result is registered, and KS_OUT waits while the held result is stalled
// key bytes are taken from idle; the final key byte runs the key schedule, one step per
// s-box entry through SCH_RN, SCH_RA, SCH_WN and SCH_WA, before the next item is taken
// reset (synchronous, rst_n low): s-box reads back as identity through per-entry
// valid bits, indices and key count cleared, no clearing pass needed
`default_nettype none

module rc4_stream_cipher_unit
  import rc4_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_key_last,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte
);

  typedef enum logic [3:0] {
    IDLE,
    KS_J,
    KS_WI,
    KS_WJ,
    KS_OUT,
    SCH_RN,
    SCH_RA,
    SCH_WN,
    SCH_WA
  } state_t;

  state_t     state_r;
  logic       out_valid_r;
  byte_t      out_byte_r;

  sbox_addr_t i_r, j_r;
  byte_t      si_r;
  sbox_addr_t t_r;
  logic       fwd_r;
  byte_t      data_r;

  key_cnt_t   key_count_r;
  key_cnt_t   len_r;
  key_idx_t   kidx_r;
  sbox_addr_t sch_n_r;
  sbox_addr_t acc_r;
  byte_t      sn_r;

  // s-box memory with per-entry valid bits (invalid entry reads as its own index)
  byte_t      sbox_mem [SBOX_SIZE];
  logic [SBOX_SIZE-1:0] sbox_vld_r;
  byte_t      sbox_q_r;
  logic       sbox_vld_q_r;
  sbox_addr_t sbox_addr_q_r;
  byte_t      sbox_q;

  // key store memory
  byte_t      key_mem [KEY_MAX];
  byte_t      key_q_r;

  logic       rd_en;
  sbox_addr_t rd_addr;
  logic       wr_en;
  sbox_addr_t wr_addr;
  byte_t      wr_data;
  logic       vld_clear;
  logic       key_wr_en;
  logic       key_rd_en;

  logic       in_xfer;
  logic       out_free;
  sbox_addr_t i_inc;
  sbox_addr_t acc_sum;
  key_cnt_t   key_count_inc;

  assign in_stall  = (state_r != IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign sbox_q        = sbox_vld_q_r ? sbox_q_r : byte_t'(sbox_addr_q_r);
  assign i_inc         = i_r + sbox_addr_t'(1);
  assign acc_sum       = acc_r + sbox_addr_t'(sbox_q) + sbox_addr_t'(key_q_r);
  assign key_count_inc = key_count_r + key_cnt_t'(1);

  // memory port control per state
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = i_inc;
    wr_en     = 1'b0;
    wr_addr   = i_r;
    wr_data   = sbox_q;
    vld_clear = 1'b0;
    key_wr_en = 1'b0;
    key_rd_en = 1'b0;
    case (state_r)
      IDLE: begin
        if (in_xfer && in_req_type == REQ_DATA) begin
          rd_en   = 1'b1;
          rd_addr = i_inc;
        end
        if (in_xfer && in_req_type == REQ_KEY) begin
          key_wr_en = (key_count_r < key_cnt_t'(KEY_MAX));
          vld_clear = in_key_last;
        end
      end
      KS_J: begin
        rd_en   = 1'b1;
        rd_addr = j_r + sbox_addr_t'(sbox_q);
      end
      KS_WI: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = sbox_q;
      end
      KS_WJ: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = si_r;
        rd_en   = 1'b1;
        rd_addr = t_r;
      end
      SCH_RN: begin
        rd_en     = 1'b1;
        rd_addr   = sch_n_r;
        key_rd_en = 1'b1;
      end
      SCH_RA: begin
        rd_en   = 1'b1;
        rd_addr = acc_sum;
      end
      SCH_WN: begin
        wr_en   = 1'b1;
        wr_addr = sch_n_r;
        wr_data = sbox_q;
      end
      SCH_WA: begin
        wr_en   = 1'b1;
        wr_addr = acc_r;
        wr_data = sn_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // s-box data array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sbox_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      sbox_q_r      <= sbox_mem[rd_addr];
      sbox_addr_q_r <= rd_addr;
    end
  end

  // s-box valid bits and registered valid of the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbox_vld_r   <= '0;
      sbox_vld_q_r <= 1'b0;
    end else begin
      if (rd_en) begin
        sbox_vld_q_r <= sbox_vld_r[rd_addr];
      end
      if (vld_clear) begin
        sbox_vld_r <= '0;
      end else if (wr_en) begin
        sbox_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // key store array
  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_count_r[KEY_IDX_W-1:0]] <= in_byte_value;
    end
    if (key_rd_en) begin
      key_q_r <= key_mem[kidx_r];
    end
  end

  // sequencer, indices and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      key_count_r <= '0;
    end else begin
      // the output state reloads the result register itself
      if (out_valid_r && !out_stall && state_r != KS_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_xfer) begin
            if (in_req_type == REQ_DATA) begin
              data_r  <= in_byte_value;
              i_r     <= i_inc;
              state_r <= KS_J;
            end else if (in_key_last) begin
              // final key byte: restart from identity and run the schedule
              len_r       <= (key_count_r < key_cnt_t'(KEY_MAX)) ? key_count_inc
                                                                 : key_count_r;
              key_count_r <= '0;
              i_r         <= '0;
              j_r         <= '0;
              acc_r       <= '0;
              sch_n_r     <= '0;
              kidx_r      <= '0;
              state_r     <= SCH_RN;
            end else if (key_count_r < key_cnt_t'(KEY_MAX)) begin
              key_count_r <= key_count_inc;
            end
          end
        end
        KS_J: begin
          si_r    <= sbox_q;
          j_r     <= j_r + sbox_addr_t'(sbox_q);
          state_r <= KS_WI;
        end
        KS_WI: begin
          t_r     <= sbox_addr_t'(si_r + sbox_q);
          state_r <= KS_WJ;
        end
        KS_WJ: begin
          // read of s[t] overlaps the write of s[j]
          fwd_r   <= (t_r == j_r);
          state_r <= KS_OUT;
        end
        KS_OUT: begin
          if (out_free) begin
            out_byte_r  <= data_r ^ (fwd_r ? si_r : sbox_q);
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        SCH_RN: begin
          state_r <= SCH_RA;
        end
        SCH_RA: begin
          sn_r    <= sbox_q;
          acc_r   <= acc_sum;
          state_r <= SCH_WN;
        end
        SCH_WN: begin
          state_r <= SCH_WA;
        end
        SCH_WA: begin
          sch_n_r <= sch_n_r + sbox_addr_t'(1);
          if (key_cnt_t'(kidx_r) == len_r - key_cnt_t'(1)) begin
            kidx_r <= '0;
          end else begin
            kidx_r <= kidx_r + key_idx_t'(1);
          end
          if (sch_n_r == sbox_addr_t'(SBOX_SIZE - 1)) begin
            state_r <= IDLE;
          end else begin
            state_r <= SCH_RN;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  // a result only appears from the output state
  a_out_from_ks: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == KS_OUT)
    else $error("result raised outside the output state");

  // stored key length stays within the key store
  a_key_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= key_cnt_t'(KEY_MAX))
    else $error("key count beyond key store depth");

  // same-entry read and write only where the keystream path forwards
  a_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en && wr_addr == rd_addr) |-> state_r == KS_WJ)
    else $error("unforwarded s-box read during write");

  // schedule runs with a nonzero key length
  a_sched_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCH_RA) |-> len_r != '0)
    else $error("key schedule with zero length");

  // the last schedule step returns to idle with the key count cleared
  a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCH_WA && sch_n_r == sbox_addr_t'(SBOX_SIZE - 1))
      |=> (state_r == IDLE && key_count_r == '0))
    else $error("key schedule did not finish cleanly");

endmodule

`default_nettype wire

// ===== dv/rc4_stream_cipher_unit_tb.sv =====
module rc4_stream_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  localparam int ITEM_TARGET   = 1950;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // a final key byte keeps the block busy for the whole key schedule
  localparam int SETTLE_CYCLES = 1100;
  localparam int IDLE_PCT      = 25;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [7:0] in_byte_value;
  logic       in_key_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;

  // shared run state
  bit         no_idle;
  int         fail_count;
  int         items_sent;
  int         cycle_count;

  // cipher state as the block should hold it
  bit [7:0]   perm [SBOX_SIZE];
  bit [7:0]   key_bytes [KEY_MAX];
  int         key_len;
  bit [7:0]   step_i;
  bit [7:0]   step_j;
  bit [7:0]   expected_bytes [$];

  rc4_stream_cipher_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_key_last   (in_key_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // permutation helpers
  function automatic void perm_swap(input bit [7:0] a, input bit [7:0] b);
    bit [7:0] t;
    t       = perm[a];
    perm[a] = perm[b];
    perm[b] = t;
  endfunction

  function automatic void perm_identity();
    for (int n = 0; n < SBOX_SIZE; n++) perm[n] = 8'(n);
    step_i = 8'h00;
    step_j = 8'h00;
  endfunction

  // key schedule over the stored key, always from a fresh identity
  function automatic void run_key_schedule(input int len);
    bit [7:0] acc;
    acc = 8'h00;
    perm_identity();
    for (int n = 0; n < SBOX_SIZE; n++) begin
      acc = acc + perm[n] + key_bytes[n % len];
      perm_swap(8'(n), acc);
    end
  endfunction

  // one keystream step
  function automatic bit [7:0] next_keystream_byte();
    bit [7:0] sel;
    step_i = step_i + 8'h01;
    step_j = step_j + perm[step_i];
    perm_swap(step_i, step_j);
    sel = perm[step_i] + perm[step_j];
    return perm[sel];
  endfunction

  // update cipher state for one accepted transfer
  function automatic void track_transfer(input logic req, input bit [7:0] val,
                                         input logic last);
    if (req == REQ_DATA) begin
      expected_bytes.push_back(val ^ next_keystream_byte());
    end else begin
      // bytes beyond the key capacity are dropped
      if (key_len < KEY_MAX) begin
        key_bytes[key_len] = val;
        key_len++;
      end
      if (last) begin
        run_key_schedule(key_len);
        key_len = 0;
      end
    end
  endfunction

  // result check
  always @(posedge clk) begin : result_check
    bit [7:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: unexpected result 8'h%02h with nothing expected", out_byte);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want) begin
          $error("out_byte mismatch: expected 8'h%02h, actual 8'h%02h", want, out_byte);
          fail_count++;
        end
      end
    end
  end

  // one transfer on the input side, entered and left at a falling edge
  task automatic send_item(input logic req, input bit [7:0] val, input logic last);
    if (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_byte_value <= val;
    in_key_last   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_transfer(req, val, last);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding byte has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // key of random bytes, optionally closed by the final-byte marker
  task automatic send_key(input int len, input bit close_key);
    for (int k = 0; k < len; k++)
      send_item(REQ_KEY, 8'($urandom), close_key && (k == len - 1));
  endtask

  // run of random data bytes, optionally with a stray final-key marker
  task automatic send_data_run(input int len, input bit stray_last);
    for (int k = 0; k < len; k++)
      send_item(REQ_DATA, 8'($urandom), stray_last ? 1'($urandom_range(1)) : 1'b0);
  endtask

  // identity s-box right after reset, marker on data has no effect
  task automatic test_data_before_key();
    send_item(REQ_DATA, 8'h00, 1'b0);
    send_item(REQ_DATA, 8'hFF, 1'b0);
    send_item(REQ_DATA, 8'hA5, 1'b1);
    send_item(REQ_DATA, 8'h5A, 1'b0);
  endtask

  // one-byte keys at both extremes
  task automatic test_single_byte_key();
    send_item(REQ_KEY,  8'h00, 1'b1);
    send_item(REQ_DATA, 8'hFF, 1'b0);
    send_item(REQ_DATA, 8'h00, 1'b0);
    send_item(REQ_KEY,  8'hFF, 1'b1);
    send_item(REQ_DATA, 8'h00, 1'b0);
    send_item(REQ_DATA, 8'hFF, 1'b1);
    send_item(REQ_DATA, 8'h3C, 1'b0);
  endtask

  // unterminated key bytes leave the s-box alone until the final byte
  task automatic test_partial_key_hold();
    send_item(REQ_KEY,  8'h12, 1'b0);
    send_item(REQ_KEY,  8'h34, 1'b0);
    send_item(REQ_DATA, 8'h00, 1'b0);
    send_item(REQ_DATA, 8'hFF, 1'b0);
    wait_for_results();
    send_item(REQ_KEY,  8'h56, 1'b1);
    send_item(REQ_DATA, 8'h80, 1'b0);
    send_item(REQ_DATA, 8'h01, 1'b0);
    wait_for_results();
  endtask

  // full-length key, then an overlong one whose tail is dropped
  task automatic test_long_keys();
    send_key(KEY_MAX, 1'b1);
    send_data_run(6, 1'b0);
    send_key(KEY_MAX + 5, 1'b1);
    send_data_run(6, 1'b0);
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back();
    wait_for_results();
    no_idle = 1'b1;
    send_key(8, 1'b1);
    send_data_run(200, 1'b0);
    wait_for_results();
    no_idle = 1'b0;
  endtask

  // mostly key-then-data sessions, with unterminated keys and loose data mixed in
  task automatic test_random_traffic();
    int kind;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        send_key(($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16),
                 1'b1);
        send_data_run($urandom_range(4, 30), 1'b0);
      end else if (kind < 90) begin
        send_key($urandom_range(1, 5), 1'b0);
        send_data_run($urandom_range(1, 10), 1'b1);
      end else begin
        send_data_run($urandom_range(1, 10), 1'b1);
      end
    end
  endtask

  // sequence
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_KEY;
    in_byte_value = 8'h00;
    in_key_last   = 1'b0;
    no_idle       = 1'b0;
    fail_count    = 0;
    items_sent    = 0;
    key_len       = 0;
    perm_identity();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_data_before_key();
    test_single_byte_key();
    test_partial_key_hold();
    test_long_keys();
    test_back_to_back();
    test_random_traffic();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rc4_pkg.sv
design/rc4_stream_cipher_unit.sv
dv/rc4_stream_cipher_unit_tb.sv
